// File: rtl/core/psdes_pkg.sv
// Shared types, constants and the round function of the pseudo-DES hash.
// Used by every module of the pseudo_des_counter_rng_core block.
package psdes_pkg;

  typedef enum logic [1:0] {
    REQ_DRAW   = 2'd0,
    REQ_HASH   = 2'd1,
    REQ_RELOAD = 2'd2
  } req_type_t;

  localparam logic [0:0] REG_SEED_HIGH = 1'b0;
  localparam logic [0:0] REG_SEED_LOW  = 1'b1;

  localparam int unsigned NumRounds = 4;

  localparam logic [31:0] RoundC1 [NumRounds] = '{
    32'hBAA96887, 32'h1E17D32C, 32'h03BCDC3C, 32'h0F33D1B2
  };
  localparam logic [31:0] RoundC2 [NumRounds] = '{
    32'h4B0F3B58, 32'hE874F0C3, 32'h6955C5A6, 32'h55A7CA46
  };

  // One queued job: the two words to hash, or a zero result when do_hash is low.
  typedef struct packed {
    logic        do_hash;
    logic [31:0] left;
    logic [31:0] right;
  } psdes_job_t;

  // Mixing function of one round applied to the right word.
  function automatic logic [31:0] psdes_mix(input logic [31:0] right, input logic [1:0] idx);
    logic [31:0] a;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [31:0] lo_sq;
    logic [31:0] hi_sq;
    logic [31:0] lo_hi;
    logic [31:0] b;
    logic [31:0] sw;
    a     = right ^ RoundC1[idx];
    lo    = a[15:0];
    hi    = a[31:16];
    lo_sq = lo * lo;
    hi_sq = hi * hi;
    lo_hi = lo * hi;
    b     = lo_sq + ~hi_sq;
    sw    = {b[15:0], b[31:16]};
    return (sw ^ RoundC2[idx]) + lo_hi;
  endfunction

endpackage

// File: rtl/core/psdes_front.sv
// Front end: takes requests, holds the seeds and the 64-bit counter, and turns
// each request into a hash job for the queue. Depends on psdes_pkg.
module psdes_front import psdes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic [1:0]  req_type,
  input  logic [63:0] hash_word,
  input  logic        queue_full,
  output logic        in_stall,
  output logic        push,
  output psdes_job_t  push_job
);

  logic [31:0] seed_high;
  logic [31:0] seed_low;
  logic [31:0] counter_high;
  logic [31:0] counter_low;
  logic [63:0] counter_next;
  logic        accept;

  assign in_stall     = queue_full;
  assign accept       = in_valid && !queue_full;
  assign push         = accept;
  assign counter_next = {counter_high, counter_low} + 64'd1;

  always_comb begin
    push_job = '0;
    unique case (req_type)
      REQ_DRAW: begin
        push_job.do_hash = 1'b1;
        push_job.left    = counter_high;
        push_job.right   = counter_low;
      end
      REQ_HASH: begin
        push_job.do_hash = 1'b1;
        push_job.left    = hash_word[63:32];
        push_job.right   = hash_word[31:0];
      end
      default: begin
        push_job = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_high    <= '0;
      seed_low     <= '0;
      counter_high <= '0;
      counter_low  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SEED_HIGH: seed_high <= cfg_data;
          REG_SEED_LOW:  seed_low  <= cfg_data;
          default:       seed_low  <= seed_low;
        endcase
      end
      if (accept) begin
        if (req_type == REQ_DRAW) begin
          counter_high <= counter_next[63:32];
          counter_low  <= counter_next[31:0];
        end else if (req_type == REQ_RELOAD) begin
          counter_high <= seed_high;
          counter_low  <= seed_low;
        end
      end
    end
  end

endmodule

// File: rtl/core/psdes_queue.sv
// Two-entry job queue between the front end and the hash engine.
// Depends on psdes_pkg for the job type.
module psdes_queue import psdes_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  psdes_job_t push_job,
  input  logic       pop,
  output logic       full,
  output logic       head_valid,
  output psdes_job_t head_job
);

  psdes_job_t  slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: rtl/core/psdes_back.sv
// Hash engine: runs the four rounds of a queued job, one round per cycle, and
// holds the result in the output register. Depends on psdes_pkg.
module psdes_back import psdes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  psdes_job_t  head_job,
  output logic        pop,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [31:0] result_high,
  output logic [31:0] result_low
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_HOLD
  } state_t;

  state_t      state;
  logic [31:0] left;
  logic [31:0] right;
  logic [1:0]  rnd;
  logic [31:0] right_next;
  logic        out_free;
  logic        out_load;

  assign out_free   = !out_valid || !out_stall;
  assign pop        = (state == ST_IDLE) && head_valid;
  assign right_next = left ^ psdes_mix(right, rnd);
  assign out_load   = out_free &&
                      (((state == ST_ROUND) && (rnd == 2'(NumRounds - 1))) ||
                       (state == ST_HOLD));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      rnd       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (head_valid) begin
            left  <= head_job.left;
            right <= head_job.right;
            rnd   <= '0;
            // Reload and unused requests skip the rounds and return zero.
            state <= head_job.do_hash ? ST_ROUND : ST_HOLD;
          end
        end
        ST_ROUND: begin
          left  <= right;
          right <= right_next;
          rnd   <= rnd + 2'd1;
          if (rnd == 2'(NumRounds - 1)) begin
            if (out_free) begin
              result_high <= right;
              result_low  <= right_next;
              state       <= ST_IDLE;
            end else begin
              state <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            result_high <= left;
            result_low  <= right;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/pseudo_des_counter_rng_core.sv
// Top level of the counter-based pseudo-DES random generator.
// Depends on psdes_pkg, psdes_front, psdes_queue and psdes_back.
//
// Usage:
//   A request arrives on in_valid/in_stall with req_type and hash_word. A draw
//   hashes the 64-bit counter and then increments it, a hash request hashes
//   hash_word, a reload copies seed_high/seed_low into the counter. Every
//   request gives exactly one result on out_valid/out_stall; reload and the
//   unused request code give a zero result.
//   The user writes the seeds through cfg_we, cfg_index and cfg_data only while idle; the block does not enforce it.
// Timing:
//   The front end takes a request in the cycle it is offered unless the
//   two-entry queue is full. The hash engine runs one round per cycle: it
//   pops a job from the queue in its idle state, runs the four rounds and
//   loads the result into the output register, raising out_valid; it pops
//   the next job only once it is idle again. A reload job skips the rounds.
//   When the receiver stalls, the result stays in the output register and the
//   engine waits with the next finished result, after which the queue fills
//   and in_stall rises.
// Reset: rst clears seeds, counter, queue and output valid.
module pseudo_des_counter_rng_core import psdes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [63:0] hash_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_high,
  output logic [31:0] result_low
);

  logic       push;
  psdes_job_t push_job;
  logic       pop;
  logic       queue_full;
  logic       head_valid;
  psdes_job_t head_job;

  psdes_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .req_type   (req_type),
    .hash_word  (hash_word),
    .queue_full (queue_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_job   (push_job)
  );

  psdes_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  psdes_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .result_high (result_high),
    .result_low  (result_low)
  );

endmodule
